// ===== hdl/afrp_pkg.sv =====
`timescale 1ns / 1ps
package afrp_pkg;

    localparam int unsigned COUNT_W   = 17;
    localparam int unsigned OFFSET_W  = 16;
    localparam int unsigned Q_DEPTH   = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [7:0] CHECKSUM_GOOD = 8'hFF;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_START_DELIM = 2'd0,
        REG_AT_TYPE     = 2'd1,
        REG_SMS_TYPE    = 2'd2,
        REG_MESH_TYPE   = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        CLASS_UNKNOWN = 2'd0,
        CLASS_AT      = 2'd1,
        CLASS_SMS     = 2'd2,
        CLASS_MESH    = 2'd3
    } t_class;

    typedef enum logic [3:0] {
        K_DELIM    = 4'd0,
        K_LENGTH   = 4'd1,
        K_TYPE     = 4'd2,
        K_ID       = 4'd3,
        K_ATCMD    = 4'd4,
        K_ATSTATUS = 4'd5,
        K_PARAM    = 4'd6,
        K_PHONE    = 4'd7,
        K_SMS      = 4'd8,
        K_ADDR     = 4'd9,
        K_RESERVED = 4'd10,
        K_OPTIONS  = 4'd11,
        K_DATA     = 4'd12,
        K_CHECKSUM = 4'd13,
        K_OTHER    = 4'd14
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_DELIM = 3'd1,
        ST_BAD_LEN   = 3'd2,
        ST_BAD_SUM   = 3'd3,
        ST_BAD_TYPE  = 3'd4,
        ST_SHORT     = 3'd5
    } t_status;

    // classified byte handed from front to back
    typedef struct packed {
        logic [7:0]          data;
        t_kind               kind;
        logic [OFFSET_W-1:0] offset;
        logic                last;
        logic                delim_chk;
        logic                sum_en;
        logic                len_bad;
        logic                type_unknown;
        logic                too_short;
    } t_item;

endpackage

// ===== hdl/afrp_front.sv =====
`timescale 1ns / 1ps
module afrp_front
    import afrp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    input  logic [7:0]  i_at_type,
    input  logic [7:0]  i_sms_type,
    input  logic [7:0]  i_mesh_type,
    output t_item       o_item,
    output logic        o_at_start
);

    logic [COUNT_W-1:0]  r_count, n_count;
    logic [15:0]         r_len, n_len;
    t_class              r_class, n_class;

    t_class              w_new_class;
    t_class              w_cls;
    t_kind               w_kind;
    logic [4:0]          w_base;
    logic                w_zero_off;
    logic [COUNT_W-1:0]  w_off_full;
    logic [4:0]          w_need_m1;

    always_comb begin
        if (i_byte == i_at_type) begin
            w_new_class = CLASS_AT;
        end else if (i_byte == i_sms_type) begin
            w_new_class = CLASS_SMS;
        end else if (i_byte == i_mesh_type) begin
            w_new_class = CLASS_MESH;
        end else begin
            w_new_class = CLASS_UNKNOWN;
        end
    end

    assign w_cls = (r_count == COUNT_W'(3)) ? w_new_class : r_class;

    // field tag and the position where the field starts
    always_comb begin
        w_kind     = K_OTHER;
        w_base     = 5'd4;
        w_zero_off = 1'b0;
        if (r_count == '0) begin
            w_kind = K_DELIM;
            w_base = 5'd0;
        end else if (r_count <= COUNT_W'(2)) begin
            w_kind = K_LENGTH;
            w_base = 5'd1;
        end else if (r_count == COUNT_W'(3)) begin
            w_kind = K_TYPE;
            w_base = 5'd3;
        end else if (i_last) begin
            w_kind     = K_CHECKSUM;
            w_zero_off = 1'b1;
        end else begin
            case (r_class)
                CLASS_AT: begin
                    if (r_count == COUNT_W'(4)) begin
                        w_kind = K_ID;       w_base = 5'd4;
                    end else if (r_count <= COUNT_W'(6)) begin
                        w_kind = K_ATCMD;    w_base = 5'd5;
                    end else if (r_count == COUNT_W'(7)) begin
                        w_kind = K_ATSTATUS; w_base = 5'd7;
                    end else begin
                        w_kind = K_PARAM;    w_base = 5'd8;
                    end
                end
                CLASS_SMS: begin
                    if (r_count <= COUNT_W'(23)) begin
                        w_kind = K_PHONE;    w_base = 5'd4;
                    end else begin
                        w_kind = K_SMS;      w_base = 5'd24;
                    end
                end
                CLASS_MESH: begin
                    if (r_count <= COUNT_W'(11)) begin
                        w_kind = K_ADDR;     w_base = 5'd4;
                    end else if (r_count <= COUNT_W'(13)) begin
                        w_kind = K_RESERVED; w_base = 5'd12;
                    end else if (r_count == COUNT_W'(14)) begin
                        w_kind = K_OPTIONS;  w_base = 5'd14;
                    end else begin
                        w_kind = K_DATA;     w_base = 5'd15;
                    end
                end
                default: begin
                    w_kind = K_OTHER;        w_base = 5'd4;
                end
            endcase
        end
    end

    assign w_off_full = r_count - COUNT_W'(w_base);

    always_comb begin
        case (w_cls)
            CLASS_AT:  w_need_m1 = 5'd8;
            CLASS_SMS: w_need_m1 = 5'd23;
            default:   w_need_m1 = 5'd15;
        endcase
    end

    always_comb begin
        o_item.data   = i_byte;
        o_item.kind   = w_kind;
        o_item.last   = i_last;
        if (w_zero_off) begin
            o_item.offset = '0;
        end else if (w_off_full[COUNT_W-1]) begin
            o_item.offset = {OFFSET_W{1'b1}};
        end else begin
            o_item.offset = w_off_full[OFFSET_W-1:0];
        end
        o_item.delim_chk    = (r_count == '0);
        o_item.sum_en       = (r_count >= COUNT_W'(3));
        // length field must equal byte count minus four
        o_item.len_bad      = (r_count < COUNT_W'(3)) ||
                              ((r_count - COUNT_W'(3)) != {1'b0, r_len});
        o_item.type_unknown = (w_cls == CLASS_UNKNOWN);
        o_item.too_short    = (r_count < COUNT_W'(w_need_m1));
    end

    always_comb begin
        n_count = r_count;
        n_len   = r_len;
        n_class = r_class;
        if (i_accept) begin
            if (r_count == COUNT_W'(1)) begin
                n_len = {i_byte, r_len[7:0]};
            end else if (r_count == COUNT_W'(2)) begin
                n_len = {r_len[15:8], i_byte};
            end
            if (r_count == COUNT_W'(3)) begin
                n_class = w_new_class;
            end
            if (i_last) begin
                n_count = '0;
                n_len   = '0;
                n_class = CLASS_UNKNOWN;
            end else if (r_count != COUNT_MAX) begin
                n_count = r_count + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_len   <= '0;
            r_class <= CLASS_UNKNOWN;
        end else begin
            r_count <= n_count;
            r_len   <= n_len;
            r_class <= n_class;
        end
    end

    assign o_at_start = (r_count == '0);

endmodule

// ===== hdl/afrp_queue.sv =====
`timescale 1ns / 1ps
module afrp_queue
    import afrp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_valid,
    output logic  o_full
);

    localparam int unsigned PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);

    t_item              r_mem [Q_DEPTH];
    logic [PTR_W-1:0]   r_wr, n_wr;
    logic [PTR_W-1:0]   r_rd, n_rd;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == CNT_W'(Q_DEPTH));
    assign o_item  = r_mem[r_rd];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(Q_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = ptr_inc(r_wr);
        end
        if (i_pop) begin
            n_rd = ptr_inc(r_rd);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

// ===== hdl/afrp_back.sv =====
`timescale 1ns / 1ps
module afrp_back
    import afrp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_item               i_item,
    input  logic                i_valid,
    output logic                o_pop,
    input  logic [7:0]          i_start_delim,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_data,
    output t_kind               o_kind,
    output logic [OFFSET_W-1:0] o_offset,
    output logic                o_last,
    output t_status             o_status
);

    logic                r_valid, n_valid;
    logic                r_delim_ok, n_delim_ok;
    logic [7:0]          r_sum, n_sum;
    logic [7:0]          r_data;
    t_kind               r_kind;
    logic [OFFSET_W-1:0] r_offset;
    logic                r_last;
    t_status             r_status;

    logic                w_delim_ok;
    logic [7:0]          w_sum;
    t_status             w_status;

    assign o_pop = i_valid && (!r_valid || i_ready);

    assign w_delim_ok = i_item.delim_chk ? (i_item.data == i_start_delim) : r_delim_ok;
    assign w_sum      = i_item.sum_en ? (r_sum + i_item.data) : r_sum;

    always_comb begin
        if (!i_item.last) begin
            w_status = ST_OK;
        end else if (!w_delim_ok) begin
            w_status = ST_BAD_DELIM;
        end else if (i_item.len_bad) begin
            w_status = ST_BAD_LEN;
        end else if (w_sum != CHECKSUM_GOOD) begin
            w_status = ST_BAD_SUM;
        end else if (i_item.type_unknown) begin
            w_status = ST_BAD_TYPE;
        end else if (i_item.too_short) begin
            w_status = ST_SHORT;
        end else begin
            w_status = ST_OK;
        end
    end

    always_comb begin
        n_valid    = r_valid;
        n_delim_ok = r_delim_ok;
        n_sum      = r_sum;
        if (o_pop) begin
            n_valid = 1'b1;
            if (i_item.last) begin
                n_delim_ok = 1'b0;
                n_sum      = '0;
            end else begin
                n_delim_ok = w_delim_ok;
                n_sum      = w_sum;
            end
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_delim_ok <= 1'b0;
            r_sum      <= '0;
        end else begin
            r_valid    <= n_valid;
            r_delim_ok <= n_delim_ok;
            r_sum      <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data   <= i_item.data;
            r_kind   <= i_item.kind;
            r_offset <= i_item.offset;
            r_last   <= i_item.last;
            r_status <= w_status;
        end
    end

    assign o_valid  = r_valid;
    assign o_data   = r_data;
    assign o_kind   = r_kind;
    assign o_offset = r_offset;
    assign o_last   = r_last;
    assign o_status = r_status;

endmodule

// ===== hdl/api_frame_receive_parser_unit.sv =====
`timescale 1ns / 1ps
// channel   direction  payload
// s_axis    in         tdata[7:0] rx_byte, tlast frame_end
// m_axis    out        tdata[7:0] data_byte, tdata[23:8] field_offset,
//                      tdata[26:24] frame_status, tuser[3:0] field_kind, tlast frame_last
// cfg       in         i_cfg_we, i_cfg_addr (register index), i_cfg_wdata
//
// one byte per cycle while m_axis_tready is high; a taken byte is queued, then registered
// the front tags each byte with its field as it arrives, a two-entry queue feeds
// the back, which keeps the checksum and delimiter check and holds the output register
// s_axis_tready drops only when the queue is full, i.e. after the output stalls
// reset (synchronous, active low) clears the frame state and restores register defaults
module api_frame_receive_parser_unit
    import afrp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] data_byte, [23:8] field_offset,
                                        // [26:24] frame_status
    output logic [3:0]  m_axis_tuser,   // [3:0] field_kind
    output logic        m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [7:0]  i_cfg_wdata
);

    logic [7:0]          r_start_delim;
    logic [7:0]          r_at_type;
    logic [7:0]          r_sms_type;
    logic [7:0]          r_mesh_type;

    logic                w_in_acc;
    t_item               w_front_item;
    t_item               w_q_item;
    logic                w_q_valid;
    logic                w_q_pop;
    logic                w_at_start;
    logic                w_q_full;
    t_kind               w_kind;
    t_status             w_status;
    logic [OFFSET_W-1:0] w_offset;
    logic [7:0]          w_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_delim <= 8'h7E;
            r_at_type     <= 8'h88;
            r_sms_type    <= 8'h9F;
            r_mesh_type   <= 8'h90;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_addr))
                REG_START_DELIM: r_start_delim <= i_cfg_wdata;
                REG_AT_TYPE:     r_at_type     <= i_cfg_wdata;
                REG_SMS_TYPE:    r_sms_type    <= i_cfg_wdata;
                REG_MESH_TYPE:   r_mesh_type   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !w_q_full;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    afrp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_in_acc),
        .i_byte      (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .i_at_type   (r_at_type),
        .i_sms_type  (r_sms_type),
        .i_mesh_type (r_mesh_type),
        .o_item      (w_front_item),
        .o_at_start  (w_at_start)
    );

    afrp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_in_acc),
        .i_item  (w_front_item),
        .i_pop   (w_q_pop),
        .o_item  (w_q_item),
        .o_valid (w_q_valid),
        .o_full  (w_q_full)
    );

    afrp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (w_q_item),
        .i_valid       (w_q_valid),
        .o_pop         (w_q_pop),
        .i_start_delim (r_start_delim),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_data        (w_data),
        .o_kind        (w_kind),
        .o_offset      (w_offset),
        .o_last        (m_axis_tlast),
        .o_status      (w_status)
    );

    assign m_axis_tdata = {5'd0, w_status, w_offset, w_data};
    assign m_axis_tuser = w_kind;

    // a frame end always returns the front to the delimiter position
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && s_axis_tlast) |=> w_at_start)
        else $error("front did not restart after frame end");

    // status is only reported on the final byte
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (w_status == ST_OK))
        else $error("status on a non-final byte");

    // checksum tag only appears on a final byte
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (w_kind == K_CHECKSUM)) |-> m_axis_tlast)
        else $error("checksum tag on a non-final byte");

    // the queue never fills while the output side is draining
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(m_axis_tready) && $past(!w_q_full)) |-> !w_q_full)
        else $error("queue filled while output was ready");

endmodule
